// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define KGSR_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define KGSR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`endif

// ----- hdl/kgsr_pkg.sv -----
// ----------------------------------------------------------------------------
// kgsr_pkg
// shared constants and types of the group reverse stream unit
// ----------------------------------------------------------------------------
package kgsr_pkg;

    localparam int MAX_GROUP    = 64;
    localparam int IDX_W        = $clog2(MAX_GROUP);
    localparam int COUNT_W      = $clog2(MAX_GROUP + 1);
    localparam int NUM_BANKS    = 2;
    localparam int MEM_DEPTH    = NUM_BANKS * MAX_GROUP;
    localparam int MEM_ADDR_W   = IDX_W + 1;
    localparam int VALUE_W      = 32;
    localparam int GSIZE_W      = 7;
    localparam logic [GSIZE_W-1:0] GSIZE_RESET = 7'd2;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    // one closed group waiting to be drained
    typedef struct packed {
        logic               bank;
        logic [COUNT_W-1:0] count;
        logic               reverse;
        logic               list_last;
    } kgsr_cmd_t;

    // buffer write request from the front
    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [VALUE_W-1:0]    data;
    } kgsr_wr_t;

    // bank handed back by the drain side
    typedef struct packed {
        logic en;
        logic bank;
    } kgsr_release_t;

    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } kgsr_back_state_t;

endpackage

// ----- hdl/kgsr_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// kgsr_cmd_fifo
// short queue of closed groups between front and back
// ----------------------------------------------------------------------------
module kgsr_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  kgsr_pkg::kgsr_cmd_t push_cmd,
    input  logic                pop,
    output kgsr_pkg::kgsr_cmd_t head,
    output logic                empty,
    output logic                full
);
    import kgsr_pkg::*;

    kgsr_cmd_t               entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    do_push, do_pop;

    always_comb
    begin
        empty       = (count_reg == '0);
        full        = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
        do_push     = push && !full;
        do_pop      = pop && !empty;
        head        = entries_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/kgsr_front.sv -----
// ----------------------------------------------------------------------------
// kgsr_front
// accepts requests, fills a buffer bank and closes groups
// ----------------------------------------------------------------------------
module kgsr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [kgsr_pkg::GSIZE_W-1:0]   cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [kgsr_pkg::VALUE_W-1:0]   item_value,
    input  logic                           list_last,
    output kgsr_pkg::kgsr_wr_t             wr,
    output logic                           cmd_push,
    output kgsr_pkg::kgsr_cmd_t            cmd,
    input  kgsr_pkg::kgsr_release_t        release_req
);
    import kgsr_pkg::*;

    logic [GSIZE_W-1:0]   group_size_reg;
    logic [COUNT_W-1:0]   fill_reg, fill_next;
    logic                 bank_reg, bank_next;
    logic [NUM_BANKS-1:0] busy_reg, busy_next;
    logic [COUNT_W-1:0]   n_items, g_eff;
    logic                 accept, complete;

    always_comb
    begin
        // zero acts as one, oversize saturates
        if (group_size_reg == '0)
        begin
            g_eff = COUNT_W'(1);
        end
        else if (int'(group_size_reg) > MAX_GROUP)
        begin
            g_eff = COUNT_W'(MAX_GROUP);
        end
        else
        begin
            g_eff = COUNT_W'(group_size_reg);
        end

        in_stall = busy_reg[bank_reg];
        accept   = in_valid && !in_stall;
        n_items  = fill_reg + COUNT_W'(1);
        complete = (n_items >= g_eff);

        wr.en    = accept;
        wr.addr  = {bank_reg, fill_reg[IDX_W-1:0]};
        wr.data  = item_value;

        cmd_push      = accept && (complete || list_last);
        cmd.bank      = bank_reg;
        cmd.count     = n_items;
        cmd.reverse   = complete;
        cmd.list_last = list_last;

        busy_next = busy_reg;
        if (release_req.en)
        begin
            busy_next[release_req.bank] = 1'b0;
        end
        fill_next = fill_reg;
        bank_next = bank_reg;
        if (cmd_push)
        begin
            busy_next[bank_reg] = 1'b1;
            fill_next           = '0;
            bank_next           = !bank_reg;
        end
        else if (accept)
        begin
            fill_next = n_items;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GSIZE_RESET;
            fill_reg       <= '0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                group_size_reg <= cfg_wr_data;
            end
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ----- hdl/kgsr_back.sv -----
// ----------------------------------------------------------------------------
// kgsr_back
// group buffer and drain sequencer driving the result channel
// ----------------------------------------------------------------------------
module kgsr_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kgsr_pkg::kgsr_wr_t             wr,
    input  kgsr_pkg::kgsr_cmd_t            fifo_head,
    input  logic                           fifo_empty,
    output logic                           fifo_pop,
    output kgsr_pkg::kgsr_release_t        release_req,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [kgsr_pkg::VALUE_W-1:0]   out_value,
    output logic                           run_last,
    output logic                           list_end
);
    import kgsr_pkg::*;

    logic [VALUE_W-1:0]    mem [MEM_DEPTH];
    kgsr_back_state_t      state_reg, state_next;
    kgsr_cmd_t             cmd_reg;
    logic [IDX_W-1:0]      k_reg;
    logic [VALUE_W-1:0]    rd_data_reg;
    logic                  out_valid_reg, run_last_reg, list_end_reg;
    logic                  slot_free, issue, k_last;
    logic [IDX_W-1:0]      idx;
    logic [MEM_ADDR_W-1:0] rd_addr;

    always_comb
    begin
        slot_free = !out_valid_reg || !out_stall;
        issue     = (state_reg == BK_DRAIN) && slot_free;
        k_last    = (COUNT_W'(k_reg) == cmd_reg.count - COUNT_W'(1));
        idx       = cmd_reg.reverse
                  ? IDX_W'(cmd_reg.count - COUNT_W'(1) - COUNT_W'(k_reg))
                  : k_reg;
        rd_addr   = {cmd_reg.bank, idx};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (issue && k_last && fifo_empty)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        fifo_pop         = 1'b0;
        release_req.en   = 1'b0;
        release_req.bank = cmd_reg.bank;
        case (state_reg)
            BK_IDLE:
            begin
                fifo_pop = !fifo_empty;
            end
            BK_DRAIN:
            begin
                fifo_pop       = issue && k_last && !fifo_empty;
                release_req.en = issue && k_last;
            end
            default:
            begin
                fifo_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            cmd_reg <= fifo_head;
            k_reg   <= '0;
        end
        else if (issue)
        begin
            k_reg <= k_reg + IDX_W'(1);
        end
        if (issue)
        begin
            run_last_reg <= k_last;
            list_end_reg <= k_last && cmd_reg.list_last;
        end
    end

    // buffer memory, registered read port doubles as the output register
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = rd_data_reg;
    assign run_last  = run_last_reg;
    assign list_end  = list_end_reg;

endmodule

// ----- hdl/k_group_stream_reverse_unit.sv -----
// ----------------------------------------------------------------------------
// k_group_stream_reverse_unit
// reverses a value stream in groups of group_size
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while a buffer bank is free and hands
// out one result per cycle while out_stall is low, from the single read port
// of the group buffer. Values fill one of two 64-entry banks; when a group of
// group_size is complete (or the list ends early) the bank is closed, queued
// and drained in reverse (or in original order for a short final group) while
// the other bank fills. For long groups the sustained rate is close to one
// request per cycle; short groups run slower, since the drain side passes its
// idle state each time it restarts from empty. A closed group is queued, then
// loaded by the drain side and read through the registered read port. Input
// stalls only while both banks hold groups not yet read out. group_size is
// written through cfg_wr_en / cfg_wr_data; the user must write it only while
// the unit is idle, the block does not enforce this. Zero acts as one, values
// above 64 act as 64, and the buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module k_group_stream_reverse_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [kgsr_pkg::GSIZE_W-1:0]   cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [kgsr_pkg::VALUE_W-1:0]   item_value,
    input  logic                           list_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [kgsr_pkg::VALUE_W-1:0]   out_value,
    output logic                           run_last,
    output logic                           list_end
);
    import kgsr_pkg::*;

    // buffer write path from front to back
    kgsr_wr_t      wr;
    // closed group handoff through the queue
    logic          cmd_push, cmd_pop, cmd_empty, cmd_full;
    kgsr_cmd_t     cmd, cmd_head;
    // bank return from the drain side
    kgsr_release_t release_req;

    // front: takes requests and closes groups
    kgsr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .item_value  (item_value),
        .list_last   (list_last),
        .wr          (wr),
        .cmd_push    (cmd_push),
        .cmd         (cmd),
        .release_req (release_req)
    );

    // queue of closed groups, one per bank at most
    kgsr_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd),
        .pop      (cmd_pop),
        .head     (cmd_head),
        .empty    (cmd_empty),
        .full     (cmd_full)
    );

    // back: buffer memory and ordered drain
    kgsr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .fifo_head   (cmd_head),
        .fifo_empty  (cmd_empty),
        .fifo_pop    (cmd_pop),
        .release_req (release_req),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_value   (out_value),
        .run_last    (run_last),
        .list_end    (list_end)
    );

    // bank gating must keep the queue from overflowing
    `KGSR_ASSERT_NEVER(a_cmd_no_overflow, clk, rst_n, cmd_push && cmd_full)
    // a closed group always holds at least one value
    `KGSR_ASSERT_IMPLIES(a_cmd_nonempty, clk, rst_n, cmd_push, cmd.count != '0)
    // a bank being released cannot be closed again in the same cycle
    `KGSR_ASSERT_NEVER(a_bank_no_reuse, clk, rst_n,
        cmd_push && release_req.en && (release_req.bank == cmd.bank))

endmodule
